>>> src/duplicate_id_filter_with_expiry_macros.svh
`ifndef DUPLICATE_ID_FILTER_WITH_EXPIRY_MACROS_SVH
`define DUPLICATE_ID_FILTER_WITH_EXPIRY_MACROS_SVH

// Checks that a condition implies another in the same cycle.
`define DIF_ASSERT_SAME(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Checks that a condition implies another in the following cycle.
`define DIF_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> src/dif_pkg.sv
`timescale 1ns / 1ps

package dif_pkg;

    localparam int ID_W        = 64;
    localparam int STAMP_W     = 32;
    localparam int OUT_CNT_W   = 5;
    localparam logic [STAMP_W-1:0] EXPIRY_RESET = 32'd30000;

    typedef struct packed {
        logic [ID_W-1:0]    msg_key;
        logic [STAMP_W-1:0] now_ms;
    } in_word_t;

    typedef struct packed {
        logic                 is_duplicate;
        logic [OUT_CNT_W-1:0] stored_count;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

endpackage

>>> src/duplicate_id_filter_with_expiry.sv
`timescale 1ns / 1ps
// An accepted word is scanned against the L live entries held when it is accepted (L is
// at most TABLE_DEPTH, none for an empty key); its result is then registered in the finish
// state, which waits while the output stalls. The scan pops one entry a cycle from the head
// cell of the chain, and no new word is taken until the last result is issued. Reset clears
// the control, sets the live count to zero and the expiry to 30000 ms; the cells are not cleared.

module duplicate_id_filter_with_expiry #(
    parameter int TABLE_DEPTH = 16,
    parameter int KEY_BITS    = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  dif_pkg::in_word_t            in_word,
    output logic                         out_valid,
    input  logic                         out_stall,
    output dif_pkg::out_word_t           out_word,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [dif_pkg::STAMP_W-1:0]  cfg_data
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    dif_pkg::state_t             state_reg;
    dif_pkg::state_t             state_next;
    logic [CNT_W-1:0]            live_count_reg;
    logic [CNT_W-1:0]            live_count_next;
    logic [CNT_W-1:0]            scan_left_reg;
    logic [CNT_W-1:0]            scan_left_next;
    logic                        dup_reg;
    logic                        dup_next;
    logic                        empty_reg;
    logic                        empty_next;
    logic [KEY_BITS-1:0]         key_reg;
    logic [KEY_BITS-1:0]         key_next;
    logic [dif_pkg::STAMP_W-1:0] now_reg;
    logic [dif_pkg::STAMP_W-1:0] now_next;
    logic [dif_pkg::STAMP_W-1:0] expiry_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    dif_pkg::out_word_t          out_word_reg;
    dif_pkg::out_word_t          out_word_next;

    logic [KEY_BITS-1:0]         cell_key   [TABLE_DEPTH];
    logic [dif_pkg::STAMP_W-1:0] cell_stamp [TABLE_DEPTH];
    dif_pkg::cell_ctl_t          cell_ctl   [TABLE_DEPTH];

    logic                        shift;
    logic                        wr_en;
    logic [IDX_W-1:0]            wr_idx;
    logic [KEY_BITS-1:0]         wr_key;
    logic [dif_pkg::STAMP_W-1:0] wr_stamp;
    logic [KEY_BITS-1:0]         in_key;
    logic                        in_empty;
    logic [dif_pkg::STAMP_W-1:0] head_age;
    logic                        head_kept;
    logic                        head_match;
    logic                        out_free;
    logic                        insert;
    logic                        full;
    logic [CNT_W-1:0]            cnt_dec;
    logic [CNT_W-1:0]            cnt_after;

    assign in_stall  = (state_reg != dif_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    assign in_key     = in_word.msg_key[KEY_BITS-1:0];
    assign in_empty   = (in_key == '0);
    assign head_age   = now_reg - cell_stamp[0];
    assign head_kept  = (head_age <= expiry_reg);
    assign head_match = (cell_key[0] == key_reg);
    assign out_free   = !out_valid_reg || !out_stall;
    assign insert     = !empty_reg && !dup_reg;
    assign full       = (live_count_reg == CNT_W'(TABLE_DEPTH));
    assign cnt_dec    = live_count_reg - 1'b1;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            assign cell_ctl[gi].shift = shift;
            assign cell_ctl[gi].load  = wr_en && (wr_idx == IDX_W'(gi));
            if (gi == TABLE_DEPTH - 1)
            begin : g_tail
                dif_cell #(
                    .KEY_BITS (KEY_BITS)
                ) u_cell (
                    .clk       (clk),
                    .ctl       (cell_ctl[gi]),
                    .wr_key    (wr_key),
                    .wr_stamp  (wr_stamp),
                    .nbr_key   (cell_key[gi]),
                    .nbr_stamp (cell_stamp[gi]),
                    .key_q     (cell_key[gi]),
                    .stamp_q   (cell_stamp[gi])
                );
            end
            else
            begin : g_body
                dif_cell #(
                    .KEY_BITS (KEY_BITS)
                ) u_cell (
                    .clk       (clk),
                    .ctl       (cell_ctl[gi]),
                    .wr_key    (wr_key),
                    .wr_stamp  (wr_stamp),
                    .nbr_key   (cell_key[gi+1]),
                    .nbr_stamp (cell_stamp[gi+1]),
                    .key_q     (cell_key[gi]),
                    .stamp_q   (cell_stamp[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dif_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_empty || (live_count_reg == '0))
                    begin
                        state_next = dif_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = dif_pkg::ST_SCAN;
                    end
                end
            end
            dif_pkg::ST_SCAN:
            begin
                if (scan_left_reg == CNT_W'(1))
                begin
                    state_next = dif_pkg::ST_FINISH;
                end
            end
            dif_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = dif_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dif_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        shift           = 1'b0;
        wr_en           = 1'b0;
        wr_idx          = '0;
        wr_key          = key_reg;
        wr_stamp        = now_reg;
        live_count_next = live_count_reg;
        scan_left_next  = scan_left_reg;
        dup_next        = dup_reg;
        empty_next      = empty_reg;
        key_next        = key_reg;
        now_next        = now_reg;
        cnt_after       = live_count_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_word_next   = out_word_reg;
        unique case (state_reg)
            dif_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    key_next       = in_key;
                    now_next       = in_word.now_ms;
                    empty_next     = in_empty;
                    dup_next       = 1'b0;
                    scan_left_next = live_count_reg;
                end
            end
            dif_pkg::ST_SCAN:
            begin
                shift          = 1'b1;
                wr_key         = cell_key[0];
                wr_stamp       = cell_stamp[0];
                scan_left_next = scan_left_reg - 1'b1;
                if (head_kept)
                begin
                    wr_en  = 1'b1;
                    wr_idx = cnt_dec[IDX_W-1:0];
                    if (head_match)
                    begin
                        dup_next = 1'b1;
                    end
                end
                else
                begin
                    live_count_next = cnt_dec;
                end
            end
            dif_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    if (insert)
                    begin
                        wr_en = 1'b1;
                        if (full)
                        begin
                            shift  = 1'b1;
                            wr_idx = IDX_W'(TABLE_DEPTH - 1);
                        end
                        else
                        begin
                            wr_idx          = live_count_reg[IDX_W-1:0];
                            cnt_after       = live_count_reg + 1'b1;
                            live_count_next = cnt_after;
                        end
                    end
                    out_valid_next              = 1'b1;
                    out_word_next.is_duplicate  = dup_reg;
                    out_word_next.stored_count  = dif_pkg::OUT_CNT_W'(cnt_after);
                end
            end
            default:
            begin
                shift = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dif_pkg::ST_IDLE;
            live_count_reg <= '0;
            scan_left_reg  <= '0;
            dup_reg        <= 1'b0;
            empty_reg      <= 1'b0;
            expiry_reg     <= dif_pkg::EXPIRY_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            live_count_reg <= live_count_next;
            scan_left_reg  <= scan_left_next;
            dup_reg        <= dup_next;
            empty_reg      <= empty_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                expiry_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        now_reg      <= now_next;
        out_word_reg <= out_word_next;
    end

`include "duplicate_id_filter_with_expiry_macros.svh"

    `DIF_ASSERT_SAME(a_count_bound, 1'b1, live_count_reg <= CNT_W'(TABLE_DEPTH), "live count exceeds depth")
    `DIF_ASSERT_NEXT(a_accept_leaves_idle, in_valid && !in_stall, state_reg != dif_pkg::ST_IDLE, "accepted word did not start work")
    `DIF_ASSERT_NEXT(a_scan_no_growth, state_reg == dif_pkg::ST_SCAN, live_count_reg <= $past(live_count_reg), "scan grew the table")
    `DIF_ASSERT_NEXT(a_finish_emits, (state_reg == dif_pkg::ST_FINISH) && out_free, out_valid_reg && (out_word_reg.is_duplicate == $past(dup_reg)), "result not emitted")

endmodule

>>> src/dif_cell.sv
`timescale 1ns / 1ps

module dif_cell #(
    parameter int KEY_BITS = 64
) (
    input  logic                         clk,
    input  dif_pkg::cell_ctl_t           ctl,
    input  logic [KEY_BITS-1:0]          wr_key,
    input  logic [dif_pkg::STAMP_W-1:0]  wr_stamp,
    input  logic [KEY_BITS-1:0]          nbr_key,
    input  logic [dif_pkg::STAMP_W-1:0]  nbr_stamp,
    output logic [KEY_BITS-1:0]          key_q,
    output logic [dif_pkg::STAMP_W-1:0]  stamp_q
);

    logic [KEY_BITS-1:0]         key_reg;
    logic [KEY_BITS-1:0]         key_next;
    logic [dif_pkg::STAMP_W-1:0] stamp_reg;
    logic [dif_pkg::STAMP_W-1:0] stamp_next;

    always_comb
    begin
        key_next   = key_reg;
        stamp_next = stamp_reg;
        if (ctl.load)
        begin
            key_next   = wr_key;
            stamp_next = wr_stamp;
        end
        else if (ctl.shift)
        begin
            key_next   = nbr_key;
            stamp_next = nbr_stamp;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        stamp_reg <= stamp_next;
    end

    assign key_q   = key_reg;
    assign stamp_q = stamp_reg;

endmodule

>>> tb/sv/dif_checker.sv
`timescale 1ns / 1ps

module dif_checker #(
    parameter int TABLE_DEPTH = 16,
    parameter int KEY_BITS    = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  dif_pkg::in_word_t           in_word,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  dif_pkg::out_word_t          out_word,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [dif_pkg::STAMP_W-1:0] cfg_data,
    output int                          mismatches,
    output int                          pending,
    output int                          words_checked,
    output int                          duplicates_seen
);

    localparam logic [dif_pkg::ID_W-1:0] KEY_MASK =
        {dif_pkg::ID_W{1'b1}} >> (dif_pkg::ID_W - KEY_BITS);

    logic [dif_pkg::ID_W-1:0]    seen_key   [TABLE_DEPTH];
    logic [dif_pkg::STAMP_W-1:0] seen_stamp [TABLE_DEPTH];
    int                          seen_count = 0;
    logic [dif_pkg::STAMP_W-1:0] expiry_ms  = dif_pkg::EXPIRY_RESET;
    dif_pkg::out_word_t          expected_verdicts [$];

    int fail_total = 0;
    int waiting    = 0;
    int checked    = 0;
    int dup_total  = 0;

    assign mismatches      = fail_total;
    assign pending         = waiting;
    assign words_checked   = checked;
    assign duplicates_seen = dup_total;

    function automatic dif_pkg::out_word_t predict_verdict(dif_pkg::in_word_t w);
        logic [dif_pkg::ID_W-1:0]    key;
        logic [dif_pkg::STAMP_W-1:0] age;
        logic                        dup;
        int                          kept;
        int                          i;
        dif_pkg::out_word_t          verdict;
        key = w.msg_key & KEY_MASK;
        dup = 1'b0;
        if (key != '0)
        begin
            kept = 0;
            for (i = 0; i < seen_count; i++)
            begin
                age = w.now_ms - seen_stamp[i];
                if (age <= expiry_ms)
                begin
                    seen_key[kept]   = seen_key[i];
                    seen_stamp[kept] = seen_stamp[i];
                    kept++;
                end
            end
            seen_count = kept;
            for (i = 0; i < seen_count; i++)
            begin
                if (seen_key[i] == key)
                begin
                    dup = 1'b1;
                end
            end
            if (!dup)
            begin
                if (seen_count >= TABLE_DEPTH)
                begin
                    for (i = 1; i < seen_count; i++)
                    begin
                        seen_key[i-1]   = seen_key[i];
                        seen_stamp[i-1] = seen_stamp[i];
                    end
                    seen_count--;
                end
                seen_key[seen_count]   = key;
                seen_stamp[seen_count] = w.now_ms;
                seen_count++;
            end
        end
        verdict.is_duplicate = dup;
        verdict.stored_count = dif_pkg::OUT_CNT_W'(seen_count);
        return verdict;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_total++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        dif_pkg::out_word_t want;
        if (!rst_n)
        begin
            seen_count = 0;
            expiry_ms  = dif_pkg::EXPIRY_RESET;
            expected_verdicts.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                expiry_ms = cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                expected_verdicts.insert(expected_verdicts.size(), predict_verdict(in_word));
            end
            if (out_valid && !out_stall)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    report_mismatch($sformatf("word with none expected (dup %0b, count %0d)",
                                              out_word.is_duplicate, out_word.stored_count));
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (out_word.is_duplicate !== want.is_duplicate)
                    begin
                        report_mismatch($sformatf("is_duplicate got %0b, expected %0b",
                                                  out_word.is_duplicate, want.is_duplicate));
                    end
                    if (out_word.stored_count !== want.stored_count)
                    begin
                        report_mismatch($sformatf("stored_count got %0d, expected %0d",
                                                  out_word.stored_count, want.stored_count));
                    end
                    checked++;
                    if (want.is_duplicate)
                    begin
                        dup_total++;
                    end
                end
            end
        end
        waiting = expected_verdicts.size();
    end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int TABLE_DEPTH = 16;
    localparam int KEY_BITS    = 64;
    localparam int LATENCY     = TABLE_DEPTH + 2;
    localparam int NUM_PHASES  = 6;
    localparam int PHASE_WORDS = 155;
    localparam int POOL_SIZE   = 24;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 300000;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        in_valid  = 1'b0;
    logic                        in_stall;
    dif_pkg::in_word_t           in_word   = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    dif_pkg::out_word_t          out_word;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [dif_pkg::STAMP_W-1:0] cfg_data  = dif_pkg::EXPIRY_RESET;

    int mismatches;
    int pending;
    int words_checked;
    int duplicates_seen;

    int          cycle_count   = 0;
    int          burst_left    = 0;
    logic        steady_flow   = 1'b0;
    logic        long_hold_req = 1'b0;

    always #4 clk = ~clk;

    duplicate_id_filter_with_expiry #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    dif_checker #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_word         (in_word),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_word        (out_word),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .pending         (pending),
        .words_checked   (words_checked),
        .duplicates_seen (duplicates_seen)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d words outstanding.",
                     cycle_count, pending);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // The receiver runs its own stall pattern, or a long hold-off when asked for one.
    initial
    begin : receiver
        int unsigned stall_mode;
        int unsigned mode_left;
        stall_mode = 0;
        mode_left  = 0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold_req = 1'b0;
                out_stall <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(20, 120);
                end
                mode_left--;
                case (stall_mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 9) < 3);
                    2:       out_stall <= ($urandom_range(0, 9) < 7);
                    default: out_stall <= (mode_left % 4 == 0);
                endcase
            end
        end
    end

    task automatic send_word(input logic [dif_pkg::ID_W-1:0] id,
                             input logic [dif_pkg::STAMP_W-1:0] stamp);
        int unsigned gap;
        in_word  <= '{msg_key: id, now_ms: stamp};
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (!steady_flow && gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (LATENCY) @(negedge clk);
    endtask

    task automatic write_expiry(input logic [dif_pkg::STAMP_W-1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [dif_pkg::STAMP_W-1:0] phase_expiry [NUM_PHASES];
        logic [dif_pkg::ID_W-1:0]    key_pool [POOL_SIZE];
        logic [dif_pkg::ID_W-1:0]    id;
        logic [dif_pkg::STAMP_W-1:0] clock_ms;
        int unsigned                 step_max;
        int unsigned                 pick;
        int                          p;
        int                          n;
        int                          k;

        phase_expiry[0] = 32'd0;
        phase_expiry[1] = 32'hFFFF_FFFF;
        phase_expiry[2] = 32'd25;
        phase_expiry[3] = dif_pkg::EXPIRY_RESET;
        phase_expiry[4] = 32'd1000;
        phase_expiry[5] = $urandom_range(1, 5000);

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_word('0, 32'd0);
        send_word('1, 32'd0);
        send_word('1, 32'd5);
        send_word(64'd1, 32'd10);
        send_word(64'h8000_0000_0000_0000, 32'd20);
        send_word('0, 32'hFFFF_FFFF);
        send_word(64'd1, 32'd3);
        for (k = 0; k < 15; k++)
        begin
            send_word(64'hA5A5_0000_0000_0000 + k + 1, 32'd100 + k);
        end
        send_word('1, 32'd200);

        clock_ms = $urandom;
        for (p = 0; p < NUM_PHASES; p++)
        begin
            drain_results();
            write_expiry(phase_expiry[p]);
            if (phase_expiry[p] == 0)
            begin
                step_max = 1;
            end
            else if (phase_expiry[p] > 32'd100000)
            begin
                step_max = 100000;
            end
            else
            begin
                step_max = phase_expiry[p] / 5 + 1;
            end
            for (k = 0; k < POOL_SIZE; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    key_pool[k] = 64'($urandom_range(1, 255));
                end
                else
                begin
                    key_pool[k] = {$urandom, $urandom};
                end
                if (key_pool[k] == '0)
                begin
                    key_pool[k] = 64'd1;
                end
            end
            steady_flow = (p == 1 || p == 4);
            if (steady_flow)
            begin
                long_hold_req = 1'b1;
            end
            for (n = 0; n < PHASE_WORDS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 5)
                begin
                    id = '0;
                end
                else if (pick < 8)
                begin
                    id = {$urandom, $urandom};
                end
                else
                begin
                    id = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                end
                pick = $urandom_range(0, 99);
                if (pick < 3)
                begin
                    clock_ms = $urandom;
                end
                else if (pick < 6)
                begin
                    clock_ms = clock_ms - $urandom_range(1, step_max);
                end
                else
                begin
                    clock_ms = clock_ms + $urandom_range(0, step_max);
                end
                send_word(id, clock_ms);
            end
        end
        steady_flow = 1'b0;
        drain_results();

        $display("Checked %0d result words, %0d of them duplicates, across %0d expiry settings.",
                 words_checked, duplicates_seen, NUM_PHASES);
        $display("Settings spanned zero and maximum expiry, with table overflow and time wrap.");
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
